/* rtl/waypoint_bearing_and_arrival_assert.svh */
// ----------------------------------------------------------------------------
// Waypoint bearing and arrival assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_BEARING_AND_ARRIVAL_ASSERT_SVH
`define WAYPOINT_BEARING_AND_ARRIVAL_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define WBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("waypoint bearing assertion failed");
// Checks that a condition leads to a consequence in the next cycle.
`define WBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waypoint bearing assertion failed");
`else
`define WBA_ASSERT(lbl, clk, rst_n, prop)
`define WBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/wba_pkg.sv */
// ----------------------------------------------------------------------------
// Waypoint bearing and arrival package
// Shared types, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package wba_pkg;

    localparam int COORD_W    = 16;
    localparam int HEAD_W     = 16;
    localparam int DIST_W     = 17;
    localparam int RADIUS_W   = 16;
    localparam int GUARD_BITS = 8;
    localparam int ANGLE_FRAC = 16;
    localparam int TABLE_LEN  = 24;
    localparam int ATAN_W     = 22;

    // Angle accumulator: degrees with 16 fractional bits, range about -100 to 280.
    localparam int ZW  = 27;
    // Heading after dropping 9 fractional bits.
    localparam int HQW = ZW - 9;

    localparam int HALF_TURN_DEG = 180;
    localparam logic signed [ZW-1:0]  HALF_TURN_Q16 = ZW'(HALF_TURN_DEG * (1 << ANGLE_FRAC));
    localparam logic signed [ZW-1:0]  HEAD_ROUND    = ZW'(1 << (ANGLE_FRAC - 8));
    localparam logic signed [HQW-1:0] FULL_TURN_Q7  = HQW'(2 * HALF_TURN_DEG * 128);
    localparam logic [15:0]           GAIN_Q16      = 16'd39797;
    localparam logic [DIST_W-1:0]     DIST_MAX      = {DIST_W{1'b1}};
    localparam int                    RADIUS_RESET  = 80;

    localparam logic REG_IDX_RADIUS = 1'b0;

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest.
    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [0:TABLE_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_NAV     = 2'd1,
        ST_ARRIVED = 2'd2
    } t_status;

    // Per-item flags that ride along the pipeline.
    typedef struct packed {
        logic idle;
        logic zero;
    } t_tag;

endpackage

/* rtl/wba_in_if.sv */
// ----------------------------------------------------------------------------
// Waypoint bearing input channel
// Valid/ready channel carrying the current and target positions.
// ----------------------------------------------------------------------------
interface wba_in_if;
    logic                         valid;
    logic                         ready;
    logic [wba_pkg::COORD_W-1:0]  current_x;
    logic [wba_pkg::COORD_W-1:0]  current_y;
    logic [wba_pkg::COORD_W-1:0]  target_x;
    logic [wba_pkg::COORD_W-1:0]  target_y;

    modport source (output valid, output current_x, output current_y,
                    output target_x, output target_y, input ready);
    modport sink   (input valid, input current_x, input current_y,
                    input target_x, input target_y, output ready);
endinterface

/* rtl/wba_out_if.sv */
// ----------------------------------------------------------------------------
// Waypoint bearing result channel
// Valid/ready channel carrying status, heading and distance.
// ----------------------------------------------------------------------------
interface wba_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [wba_pkg::HEAD_W-1:0]  heading;
    logic [wba_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output status, output heading,
                    output distance, input ready);
    modport sink   (input valid, input status, input heading,
                    input distance, output ready);
endinterface

/* rtl/wba_cordic_stage.sv */
// ----------------------------------------------------------------------------
// Waypoint bearing CORDIC stage
// One registered vectoring micro-rotation with its angle from the table.
// ----------------------------------------------------------------------------
module wba_cordic_stage #(
    parameter int XW    = 27,
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [XW-1:0]        i_x,
    input  logic signed [XW-1:0]        i_y,
    input  logic signed [wba_pkg::ZW-1:0] i_z,
    input  wba_pkg::t_tag               i_tag,
    output logic                        o_valid,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic signed [wba_pkg::ZW-1:0] o_z,
    output wba_pkg::t_tag               o_tag
);

    logic signed [XW-1:0]          s_xs;
    logic signed [XW-1:0]          s_ys;
    logic signed [wba_pkg::ZW-1:0] s_ang;
    logic                          s_up;

    logic                          r_valid;
    logic signed [XW-1:0]          r_x, n_x;
    logic signed [XW-1:0]          r_y, n_y;
    logic signed [wba_pkg::ZW-1:0] r_z, n_z;
    wba_pkg::t_tag                 r_tag;

    // Arithmetic shifts round toward minus infinity.
    assign s_xs  = i_x >>> SHIFT;
    assign s_ys  = i_y >>> SHIFT;
    assign s_ang = $signed({{(wba_pkg::ZW - wba_pkg::ATAN_W){1'b0}},
                            wba_pkg::ATAN_DEG_Q16[SHIFT]});
    assign s_up  = !i_y[XW-1] && (i_y != '0);

    always_comb begin
        if (s_up) begin
            n_x = i_x + s_ys;
            n_y = i_y - s_xs;
            n_z = i_z + s_ang;
        end else begin
            n_x = i_x - s_ys;
            n_y = i_y + s_xs;
            n_z = i_z - s_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

/* rtl/waypoint_bearing_and_arrival.sv */
// ----------------------------------------------------------------------------
// Waypoint bearing and arrival
// Pipelined CORDIC vectoring unit giving bearing, distance and arrival status.
// ----------------------------------------------------------------------------
// Usage:
// Position pairs arrive on i_in as valid/ready transfers; each transfer gives
// exactly one result transfer on o_res with status, heading and distance.
// A target of zero reports idle with heading and distance zero.
// The datapath is an input register, CORDIC_STAGES micro-rotation registers
// (at most TABLE_LEN), a gain-multiply register and an output register. One
// item can enter every cycle while the receiver takes the results, so the
// sustained rate is then one item per cycle.
// The whole pipeline advances together: when the output register holds a
// result that the receiver does not take, every stage holds and i_in.ready
// drops, so nothing is lost or repeated. Bubbles keep their place during a stall.
// Reset is synchronous and active low; it clears all valid bits and sets
// arrive_radius to 80 (5 px). The radius register sits at APB address 0, and
// the user must write it only while the pipeline is empty; no logic checks it.
// ----------------------------------------------------------------------------
`include "waypoint_bearing_and_arrival_assert.svh"

module waypoint_bearing_and_arrival #(
    parameter int CORDIC_STAGES  = 16,
    parameter int COORD_INT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wba_in_if.sink      i_in,
    wba_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW = (COORD_INT_BITS + 4 > wba_pkg::COORD_W) ?
                        wba_pkg::COORD_W : COORD_INT_BITS + 4;
    localparam int GB = wba_pkg::GUARD_BITS;
    localparam int XW = EW + 1 + GB + 2;
    localparam int NS = (CORDIC_STAGES > wba_pkg::TABLE_LEN) ?
                        wba_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int PW = XW - 1 + 16;
    localparam int RS = wba_pkg::ANGLE_FRAC + GB;
    localparam int DFW = (PW - RS > wba_pkg::DIST_W + 1) ? PW - RS : wba_pkg::DIST_W + 1;
    localparam int ZW  = wba_pkg::ZW;
    localparam int HQW = wba_pkg::HQW;

    logic en;

    // ---------------- configuration ----------------
    logic [wba_pkg::RADIUS_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= wba_pkg::RADIUS_W'(wba_pkg::RADIUS_RESET);
        end else if (psel && penable && pwrite && paddr[2] == wba_pkg::REG_IDX_RADIUS) begin
            r_radius <= pwdata[wba_pkg::RADIUS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wba_pkg::REG_IDX_RADIUS) ?
                    {{(32 - wba_pkg::RADIUS_W){1'b0}}, r_radius} : 32'd0;

    // ---------------- input stage ----------------
    logic [EW-1:0]        s_cx, s_cy, s_tx, s_ty;
    logic signed [EW:0]   s_dx, s_dy;
    logic signed [XW-1:0] s_xe, s_ye;

    logic                 r_v0;
    logic signed [XW-1:0] r_x0, n_x0;
    logic signed [XW-1:0] r_y0, n_y0;
    logic signed [ZW-1:0] r_z0, n_z0;
    wba_pkg::t_tag        r_tag0, n_tag0;

    assign s_cx = i_in.current_x[EW-1:0];
    assign s_cy = i_in.current_y[EW-1:0];
    assign s_tx = i_in.target_x[EW-1:0];
    assign s_ty = i_in.target_y[EW-1:0];
    assign s_dx = $signed({1'b0, s_tx}) - $signed({1'b0, s_cx});
    assign s_dy = $signed({1'b0, s_cy}) - $signed({1'b0, s_ty});
    assign s_xe = {{2{s_dx[EW]}}, s_dx, {GB{1'b0}}};
    assign s_ye = {{2{s_dy[EW]}}, s_dy, {GB{1'b0}}};

    // A vector in the left half plane is turned by 180 degrees first.
    always_comb begin
        n_tag0.idle = (s_tx == '0) && (s_ty == '0);
        n_tag0.zero = (s_dx == '0) && (s_dy == '0);
        if (s_dx[EW]) begin
            n_x0 = -s_xe;
            n_y0 = -s_ye;
            n_z0 = wba_pkg::HALF_TURN_Q16;
        end else begin
            n_x0 = s_xe;
            n_y0 = s_ye;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0   <= n_x0;
            r_y0   <= n_y0;
            r_z0   <= n_z0;
            r_tag0 <= n_tag0;
        end
    end

    // ---------------- CORDIC stages ----------------
    logic                 w_v   [0:NS];
    logic signed [XW-1:0] w_x   [0:NS];
    logic signed [XW-1:0] w_y   [0:NS];
    logic signed [ZW-1:0] w_z   [0:NS];
    wba_pkg::t_tag        w_tag [0:NS];

    assign w_v[0]   = r_v0;
    assign w_x[0]   = r_x0;
    assign w_y[0]   = r_y0;
    assign w_z[0]   = r_z0;
    assign w_tag[0] = r_tag0;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        wba_cordic_stage #(
            .XW    (XW),
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_tag   (w_tag[k]),
            .o_valid (w_v[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    // ---------------- gain multiply and heading rounding ----------------
    logic [XW-2:0]         s_xpos;
    logic signed [ZW-1:0]  s_hz, s_hsh;

    logic                  r_mv;
    logic [PW-1:0]         r_prod, n_prod;
    logic signed [HQW-1:0] r_hq, n_hq;
    wba_pkg::t_tag         r_mtag;

    assign s_xpos = w_x[NS][XW-1] ? '0 : w_x[NS][XW-2:0];
    assign n_prod = PW'(s_xpos) * PW'(wba_pkg::GAIN_Q16);
    assign s_hz   = w_z[NS] + wba_pkg::HEAD_ROUND;
    assign s_hsh  = s_hz >>> (ZW - HQW);
    assign n_hq   = s_hsh[HQW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= w_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= n_prod;
            r_hq   <= n_hq;
            r_mtag <= w_tag[NS];
        end
    end

    // ---------------- output stage ----------------
    logic [PW:0]                 s_rnd;
    logic [DFW-1:0]              s_dfull;
    logic [wba_pkg::DIST_W-1:0]  s_dsat;
    logic signed [HQW-1:0]       s_hw;

    logic                        r_ov;
    wba_pkg::t_status            r_status, n_status;
    logic [wba_pkg::HEAD_W-1:0]  r_head, n_head;
    logic [wba_pkg::DIST_W-1:0]  r_dist, n_dist;

    assign s_rnd   = {1'b0, r_prod} + ((PW + 1)'(1) << (RS - 1));
    assign s_dfull = DFW'(s_rnd[PW:RS]);
    assign s_dsat  = (s_dfull > DFW'(wba_pkg::DIST_MAX)) ? wba_pkg::DIST_MAX :
                     s_dfull[wba_pkg::DIST_W-1:0];

    always_comb begin
        priority if (r_hq < 0) begin
            s_hw = r_hq + wba_pkg::FULL_TURN_Q7;
        end else if (r_hq >= wba_pkg::FULL_TURN_Q7) begin
            s_hw = r_hq - wba_pkg::FULL_TURN_Q7;
        end else begin
            s_hw = r_hq;
        end
    end

    always_comb begin
        if (r_mtag.idle || r_mtag.zero) begin
            n_head = '0;
            n_dist = '0;
        end else begin
            n_head = s_hw[wba_pkg::HEAD_W-1:0];
            n_dist = s_dsat;
        end
        if (r_mtag.idle) begin
            n_status = wba_pkg::ST_IDLE;
        end else if (n_dist < {1'b0, r_radius}) begin
            n_status = wba_pkg::ST_ARRIVED;
        end else begin
            n_status = wba_pkg::ST_NAV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= n_status;
            r_head   <= n_head;
            r_dist   <= n_dist;
        end
    end

    // The pipeline moves whenever the output register is empty or being drained.
    assign en          = !r_ov || o_res.ready;
    assign i_in.ready  = en;
    assign o_res.valid    = r_ov;
    assign o_res.status   = r_status;
    assign o_res.heading  = r_head;
    assign o_res.distance = r_dist;

    // ---------------- assertions ----------------
    `WBA_ASSERT(a_ready_follows_output, i_clk, i_rst_n,
                i_in.ready == (!o_res.valid || o_res.ready))
    `WBA_ASSERT_NEXT(a_mult_to_output, i_clk, i_rst_n, r_mv && en, o_res.valid)
    `WBA_ASSERT_NEXT(a_idle_status, i_clk, i_rst_n, r_mv && en && r_mtag.idle,
                     o_res.status == wba_pkg::ST_IDLE && o_res.heading == '0 &&
                     o_res.distance == '0)

endmodule
